// ===== rtl/nearest_centroid_assign_macros.svh =====
// ----------------------------------------------------------------------------
// nearest_centroid_assign_macros
// assertion macros shared by the nearest centroid assignment block
// ----------------------------------------------------------------------------
`ifndef NEAREST_CENTROID_ASSIGN_MACROS_SVH
`define NEAREST_CENTROID_ASSIGN_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define NCA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NCA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ncent_pkg.sv =====
// ----------------------------------------------------------------------------
// ncent_pkg
// types and fixed constants of the nearest centroid assignment block
// ----------------------------------------------------------------------------
package ncent_pkg;

   localparam int COORD_W    = 16;
   localparam int DIST_W     = 36;
   localparam int SQ_W       = 32;
   localparam int OUT_IDX_W  = 4;
   localparam int IN_IDX_W   = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CENTROIDS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIMS      = 1'b1;

   localparam logic [CSR_DATA_W-1:0] RST_NUM_CENTROIDS = 5'd1;
   localparam logic [CSR_DATA_W-1:0] RST_NUM_DIMS      = 5'd16;

   // item modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_POINT = 1'b1;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef struct packed {
      logic                       mode;
      logic [IN_IDX_W-1:0]        centroid_index;
      logic [IN_IDX_W-1:0]        coord_index;
      logic signed [COORD_W-1:0]  coord_value;
   } req_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] nearest_index;
      logic [DIST_W-1:0]    best_distance;
      logic                 no_centroids;
   } rsp_type;

   // one point coordinate handed to the sweep sequencer
   typedef struct packed {
      logic                      valid;
      logic                      clear;
      logic                      emit;
      logic signed [COORD_W-1:0] value;
   } sweep_cmd_type;

endpackage

// ===== rtl/ncent_cmem.sv =====
// ----------------------------------------------------------------------------
// ncent_cmem
// centroid coordinate memory, one write port, one registered read port
// ----------------------------------------------------------------------------
module ncent_cmem #(
   parameter int MAX_CENTROIDS = 16,
   parameter int MAX_DIMS      = 16,
   localparam int DEPTH  = MAX_CENTROIDS * MAX_DIMS,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [ADDR_W-1:0]                   wr_addr,
   input  logic signed [ncent_pkg::COORD_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]                   rd_addr,
   output logic signed [ncent_pkg::COORD_W-1:0] rd_data
);
   import ncent_pkg::*;

   logic signed [COORD_W-1:0] mem [DEPTH];
   logic signed [COORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ncent_pmem.sv =====
// ----------------------------------------------------------------------------
// ncent_pmem
// partial distance memory, one entry per centroid, registered read
// ----------------------------------------------------------------------------
module ncent_pmem #(
   parameter int MAX_CENTROIDS = 16,
   localparam int CIDX_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [CIDX_W-1:0]              wr_addr,
   input  logic [ncent_pkg::DIST_W-1:0]   wr_data,
   input  logic [CIDX_W-1:0]              rd_addr,
   output logic [ncent_pkg::DIST_W-1:0]   rd_data
);
   import ncent_pkg::*;

   logic [DIST_W-1:0] mem [MAX_CENTROIDS];
   logic [DIST_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ncent_sweep.sv =====
// ----------------------------------------------------------------------------
// ncent_sweep
// per-coordinate sweep over all centroids: read, square, accumulate, argmin
// ----------------------------------------------------------------------------
`include "nearest_centroid_assign_macros.svh"

module ncent_sweep #(
   parameter int MAX_CENTROIDS = 16,
   parameter int MAX_DIMS      = 16,
   localparam int CIDX_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1,
   localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
   localparam int CCNT_W = $clog2(MAX_CENTROIDS + 1),
   localparam int DEPTH  = MAX_CENTROIDS * MAX_DIMS,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ncent_pkg::sweep_cmd_type             cmd,
   input  logic [DIM_W-1:0]                     cmd_dim,
   input  logic [CCNT_W-1:0]                    cent_count,
   output logic                                 busy,
   output logic [ADDR_W-1:0]                    cm_rd_addr,
   input  logic signed [ncent_pkg::COORD_W-1:0] cm_rd_data,
   output logic [CIDX_W-1:0]                    pm_rd_addr,
   input  logic [ncent_pkg::DIST_W-1:0]         pm_rd_data,
   output logic                                 pm_we,
   output logic [CIDX_W-1:0]                    pm_wr_addr,
   output logic [ncent_pkg::DIST_W-1:0]         pm_wr_data,
   output logic                                 rsp_strobe,
   output ncent_pkg::rsp_type                   rsp_data
);
   import ncent_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type                 state_ff;
   logic [CIDX_W-1:0]         issue_j_ff;
   logic [DIM_W-1:0]          dim_ff;
   logic signed [COORD_W-1:0] value_ff;
   logic                      emit_ff;
   logic                      fresh_ff;
   logic                      have_ff;
   logic [CIDX_W-1:0]         best_i_ff;
   logic [DIST_W-1:0]         best_d_ff;
   logic                      rsp_strobe_ff;
   rsp_type                   rsp_data_ff;

   // pipeline: s1 = memory data back, s2 = difference, s3 = square
   logic                      v1_ff, v2_ff, v3_ff;
   logic                      last1_ff, last2_ff, last3_ff;
   logic [CIDX_W-1:0]         j1_ff, j2_ff, j3_ff;
   logic signed [COORD_W:0]   diff2_ff;
   logic [DIST_W-1:0]         part2_ff, part3_ff;
   logic [SQ_W-1:0]           sq3_ff;

   logic                      issue_last;
   logic signed [COORD_W:0]   diff_in;
   logic [DIST_W-1:0]         part_in;
   logic signed [2*COORD_W+1:0] sq_full;
   logic [DIST_W:0]           sum_full;
   logic [DIST_W-1:0]         sum_sat;
   logic                      in_range;

   assign issue_last = (32'(issue_j_ff) == MAX_CENTROIDS - 1);
   assign cm_rd_addr = ADDR_W'(32'(issue_j_ff) * MAX_DIMS + 32'(dim_ff));
   assign pm_rd_addr = issue_j_ff;

   // reads of the sum memory count as zero right after a clear or a result
   assign part_in  = fresh_ff ? '0 : pm_rd_data;
   assign diff_in  = COORD_W'(value_ff) - COORD_W'(cm_rd_data) == '0 ? '0 :
                     $signed({value_ff[COORD_W-1], value_ff}) -
                     $signed({cm_rd_data[COORD_W-1], cm_rd_data});
   assign sq_full  = (2*COORD_W+2)'(diff2_ff) * (2*COORD_W+2)'(diff2_ff);
   assign sum_full = {1'b0, part3_ff} + (DIST_W + 1)'(sq3_ff);
   assign sum_sat  = sum_full[DIST_W] ? DIST_MAX : sum_full[DIST_W-1:0];
   assign in_range = (CCNT_W'(j3_ff) < cent_count);

   assign pm_we      = v3_ff;
   assign pm_wr_addr = j3_ff;
   assign pm_wr_data = sum_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= (state_ff == ST_ISSUE);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      last1_ff <= issue_last;
      j1_ff    <= issue_j_ff;
      last2_ff <= last1_ff;
      j2_ff    <= j1_ff;
      diff2_ff <= diff_in;
      part2_ff <= part_in;
      last3_ff <= last2_ff;
      j3_ff    <= j2_ff;
      sq3_ff   <= sq_full[SQ_W-1:0];
      part3_ff <= part2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_j_ff    <= '0;
         emit_ff       <= 1'b0;
         fresh_ff      <= 1'b1;
         have_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == ST_FINISH) && emit_ff;
         if (v3_ff && in_range && (!have_ff || sum_sat < best_d_ff)) begin
            have_ff   <= 1'b1;
            best_i_ff <= j3_ff;
            best_d_ff <= sum_sat;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.valid) begin
                  state_ff   <= ST_ISSUE;
                  issue_j_ff <= '0;
                  dim_ff     <= cmd_dim;
                  value_ff   <= cmd.value;
                  emit_ff    <= cmd.emit;
                  fresh_ff   <= fresh_ff | cmd.clear;
                  have_ff    <= 1'b0;
               end
            end
            ST_ISSUE: begin
               issue_j_ff <= issue_j_ff + 1'b1;
               if (issue_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (v3_ff && last3_ff) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               state_ff      <= ST_IDLE;
               fresh_ff      <= emit_ff;
               if (cent_count == '0) begin
                  rsp_data_ff.nearest_index <= '0;
                  rsp_data_ff.best_distance <= '0;
                  rsp_data_ff.no_centroids  <= 1'b1;
               end else begin
                  rsp_data_ff.nearest_index <= OUT_IDX_W'(best_i_ff);
                  rsp_data_ff.best_distance <= best_d_ff;
                  rsp_data_ff.no_centroids  <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `NCA_ASSERT_NEXT(a_rsp_single, rsp_strobe_ff, !rsp_strobe_ff, "result strobe held")
   `NCA_ASSERT_NOW(a_wb_busy, pm_we, state_ff != ST_IDLE, "sum write while idle")
   `NCA_ASSERT_NOW(a_have_best, state_ff == ST_FINISH && cent_count != '0, have_ff,
      "no candidate at finish")
   `NCA_ASSERT_NOW(a_none_zero, rsp_strobe_ff && rsp_data_ff.no_centroids,
      rsp_data_ff.best_distance == '0 && rsp_data_ff.nearest_index == '0,
      "empty result carries data")

endmodule

// ===== rtl/nearest_centroid_assign.sv =====
// ----------------------------------------------------------------------------
// nearest_centroid_assign
// nearest centroid assignment for k-means over signed 16-bit coordinates
// ----------------------------------------------------------------------------
// usage
//   req channel: start/busy command port, req_data carries one coordinate;
//     a transfer happens at a clock edge with start high and busy low
//   load items (mode 0) write one centroid coordinate in the transfer cycle
//     and never raise busy; point items beyond the dimension count are dropped
//   point items (mode 1) sweep all MAX_CENTROIDS sum entries through the
//     sum memory, one entry per cycle, then a 3-stage read/diff/square pipe
//     that adds into the sum entry; busy stays high through sweep and drain
//   on the last coordinate of a point the result is shown on rsp_data with
//     rsp_strobe for exactly one cycle, the first cycle with busy low; the
//     receiver cannot stall, each strobe is one transfer
//   csr port: csr_we writes csr_index (0 num_centroids, 1 num_dims) at once
//   reset: synchronous; registers take their defaults and the partial sums
//     read as zero; centroid memory holds no defined values until loaded
// ----------------------------------------------------------------------------
module nearest_centroid_assign #(
   parameter int MAX_CENTROIDS = 16,
   parameter int MAX_DIMS      = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ncent_pkg::req_type                req_data,
   output logic                              rsp_strobe,
   output ncent_pkg::rsp_type                rsp_data,
   input  logic                              csr_we,
   input  logic [ncent_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ncent_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ncent_pkg::*;

   localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CIDX_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
   localparam int CCNT_W = $clog2(MAX_CENTROIDS + 1);
   localparam int DCNT_W = $clog2(MAX_DIMS + 1);
   localparam int DEPTH  = MAX_CENTROIDS * MAX_DIMS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration registers
   logic [CSR_DATA_W-1:0] num_centroids_ff;
   logic [CSR_DATA_W-1:0] num_dims_ff;

   logic [CCNT_W-1:0]     cent_count;
   logic [DCNT_W-1:0]     dim_count;
   logic                  req_fire;
   logic                  load_ok;
   logic                  point_ok;
   sweep_cmd_type         cmd;

   logic                  cm_we;
   logic [ADDR_W-1:0]     cm_wr_addr;
   logic [ADDR_W-1:0]     cm_rd_addr;
   logic signed [COORD_W-1:0] cm_rd_data;

   logic                  pm_we;
   logic [CIDX_W-1:0]     pm_wr_addr;
   logic [DIST_W-1:0]     pm_wr_data;
   logic [CIDX_W-1:0]     pm_rd_addr;
   logic [DIST_W-1:0]     pm_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_centroids_ff <= RST_NUM_CENTROIDS;
         num_dims_ff      <= RST_NUM_DIMS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_CENTROIDS: num_centroids_ff <= csr_wdata;
            CSR_NUM_DIMS:      num_dims_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // effective counts: zero dims acts as one, both clamp to the table size
   assign cent_count = (32'(num_centroids_ff) > MAX_CENTROIDS) ?
                       CCNT_W'(MAX_CENTROIDS) : CCNT_W'(num_centroids_ff);
   assign dim_count  = (num_dims_ff == '0) ? DCNT_W'(1) :
                       (32'(num_dims_ff) > MAX_DIMS) ? DCNT_W'(MAX_DIMS) :
                       DCNT_W'(num_dims_ff);

   assign req_fire = start && !busy;

   // load transfer: store one coordinate if it lands inside the table
   assign load_ok    = (32'(req_data.centroid_index) < MAX_CENTROIDS) &&
                       (32'(req_data.coord_index) < MAX_DIMS);
   assign cm_we      = req_fire && (req_data.mode == MODE_LOAD) && load_ok;
   assign cm_wr_addr = ADDR_W'(32'(req_data.centroid_index) * MAX_DIMS +
                               32'(req_data.coord_index));

   // point transfer: only coordinates inside the dimension count do work
   assign point_ok  = (32'(req_data.coord_index) < 32'(dim_count));
   assign cmd.valid = req_fire && (req_data.mode == MODE_POINT) && point_ok;
   assign cmd.clear = (req_data.coord_index == '0);
   assign cmd.emit  = (32'(req_data.coord_index) == 32'(dim_count) - 1);
   assign cmd.value = req_data.coord_value;

   ncent_cmem #(
      .MAX_CENTROIDS (MAX_CENTROIDS),
      .MAX_DIMS      (MAX_DIMS)
   ) u_cmem (
      .clock   (clock),
      .wr_en   (cm_we),
      .wr_addr (cm_wr_addr),
      .wr_data (req_data.coord_value),
      .rd_addr (cm_rd_addr),
      .rd_data (cm_rd_data)
   );

   ncent_pmem #(
      .MAX_CENTROIDS (MAX_CENTROIDS)
   ) u_pmem (
      .clock   (clock),
      .wr_en   (pm_we),
      .wr_addr (pm_wr_addr),
      .wr_data (pm_wr_data),
      .rd_addr (pm_rd_addr),
      .rd_data (pm_rd_data)
   );

   ncent_sweep #(
      .MAX_CENTROIDS (MAX_CENTROIDS),
      .MAX_DIMS      (MAX_DIMS)
   ) u_sweep (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_dim    (DIM_W'(req_data.coord_index)),
      .cent_count (cent_count),
      .busy       (busy),
      .cm_rd_addr (cm_rd_addr),
      .cm_rd_data (cm_rd_data),
      .pm_rd_addr (pm_rd_addr),
      .pm_rd_data (pm_rd_data),
      .pm_we      (pm_we),
      .pm_wr_addr (pm_wr_addr),
      .pm_wr_data (pm_wr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
